// ===== design/mcfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfb_pkg
// Request and response types and codes shared by the FIFO bank files.
// ----------------------------------------------------------------------------
package mcfb_pkg;

	localparam logic [1:0] REQ_INIT  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADIDX = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  fifo_index;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_data;
		logic [31:0] lost_count;
	} rsp_t;

endpackage

// ===== design/mcfb_store.sv =====
// ----------------------------------------------------------------------------
// mcfb_store
// Simple dual-port word memory: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module mcfb_store #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 32,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/multi_channel_fifo_bank.sv =====
// ----------------------------------------------------------------------------
// multi_channel_fifo_bank
// A bank of independent circular FIFOs sharing one word memory. Each
// transaction inits, writes or reads one FIFO and returns one response.
// ----------------------------------------------------------------------------
// The response strobe (done) comes in the cycle after start is taken.
// Throughput: one transaction per cycle; busy stays low, since the pointer
// and count registers update at the accepting edge and the word memory has
// one write and one read port with a registered read.
// Reset: arst_n clears all pointers, fill counts and lost counters at once;
// the word memory is not cleared and needs no clearing pass.
module multi_channel_fifo_bank #(
	parameter int FIFO_DEPTH = 16,
	parameter int NUM_FIFOS  = 4,
	parameter int WORD_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mcfb_pkg::req_t req,
	output logic          done,
	output mcfb_pkg::rsp_t rsp
);

	import mcfb_pkg::*;

	localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
	localparam int SEL_W  = (NUM_FIFOS > 1) ? $clog2(NUM_FIFOS) : 1;
	localparam int DEPTH  = NUM_FIFOS * FIFO_DEPTH;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [PTR_W-1:0] rd_ptr_q  [NUM_FIFOS];
	logic [PTR_W-1:0] wr_ptr_q  [NUM_FIFOS];
	logic [CNT_W-1:0] fill_q    [NUM_FIFOS];
	logic [31:0]      lost_q    [NUM_FIFOS];

	logic             accept;
	logic             bad_idx;
	logic [SEL_W-1:0] sel;
	logic [PTR_W-1:0] cur_rd_ptr, cur_wr_ptr, nxt_rd_ptr, nxt_wr_ptr;
	logic [CNT_W-1:0] cur_fill;
	logic [31:0]      cur_lost, nxt_lost;
	logic             is_full, is_empty;
	logic             do_write, do_read, do_init, do_drop;
	logic [1:0]       status_c;
	logic [ADDR_W-1:0] base_addr, wr_addr, rd_addr;
	logic [63:0]      wr_wide, rd_wide;
	logic [WORD_WIDTH-1:0] wr_word, rd_word;

	logic             done_s1;
	logic             rd_ok_s1;
	logic [1:0]       status_s1;
	logic [31:0]      lost_s1;

	assign accept  = start && !busy;
	assign busy    = 1'b0;
	assign bad_idx = (32'(req.fifo_index) >= 32'(NUM_FIFOS));
	assign sel     = SEL_W'(req.fifo_index);

	assign cur_rd_ptr = rd_ptr_q[sel];
	assign cur_wr_ptr = wr_ptr_q[sel];
	assign cur_fill   = fill_q[sel];
	assign cur_lost   = lost_q[sel];

	assign is_full  = (cur_fill == CNT_W'(FIFO_DEPTH));
	assign is_empty = (cur_fill == '0);

	assign do_init  = accept && !bad_idx && (req.req_type == REQ_INIT);
	assign do_write = accept && !bad_idx && (req.req_type == REQ_WRITE) && !is_full;
	assign do_drop  = accept && !bad_idx && (req.req_type == REQ_WRITE) && is_full;
	assign do_read  = accept && !bad_idx && (req.req_type == REQ_READ) && !is_empty;

	// Pointers wrap at the FIFO depth, which need not be a power of two.
	assign nxt_wr_ptr = (cur_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : cur_wr_ptr + 1'b1;
	assign nxt_rd_ptr = (cur_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : cur_rd_ptr + 1'b1;

	always_comb begin
		nxt_lost = cur_lost;
		if (do_init) begin
			nxt_lost = '0;
		end else if (do_drop && (cur_lost != '1)) begin
			nxt_lost = cur_lost + 32'd1;
		end
	end

	always_comb begin
		priority if (bad_idx) begin
			status_c = ST_BADIDX;
		end else if (req.req_type == REQ_WRITE && is_full) begin
			status_c = ST_FULL;
		end else if (req.req_type == REQ_READ && is_empty) begin
			status_c = ST_EMPTY;
		end else begin
			status_c = ST_OK;
		end
	end

	assign base_addr = ADDR_W'(sel) * ADDR_W'(FIFO_DEPTH);
	assign wr_addr   = base_addr + ADDR_W'(cur_wr_ptr);
	assign rd_addr   = base_addr + ADDR_W'(cur_rd_ptr);

	assign wr_wide = {32'd0, req.write_data};
	assign wr_word = wr_wide[WORD_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FIFOS; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				fill_q[i]   <= '0;
				lost_q[i]   <= '0;
			end
		end else begin
			if (do_init) begin
				rd_ptr_q[sel] <= '0;
				wr_ptr_q[sel] <= '0;
				fill_q[sel]   <= '0;
			end
			if (do_write) begin
				wr_ptr_q[sel] <= nxt_wr_ptr;
				fill_q[sel]   <= cur_fill + 1'b1;
			end
			if (do_read) begin
				rd_ptr_q[sel] <= nxt_rd_ptr;
				fill_q[sel]   <= cur_fill - 1'b1;
			end
			if (do_init || do_drop) begin
				lost_q[sel] <= nxt_lost;
			end
		end
	end

	mcfb_store #(
		.DEPTH  (DEPTH),
		.DATA_W (WORD_WIDTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (do_write),
		.wr_addr (wr_addr),
		.wr_data (wr_word),
		.rd_en   (do_read),
		.rd_addr (rd_addr),
		.rd_data (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_s1  <= do_read;
			status_s1 <= status_c;
			lost_s1   <= bad_idx ? 32'd0 : nxt_lost;
		end
	end

	always_comb begin
		rd_wide = '0;
		rd_wide[WORD_WIDTH-1:0] = rd_word;
	end

	assign done           = done_s1;
	assign rsp.status     = status_s1;
	assign rsp.read_data  = rd_ok_s1 ? rd_wide[31:0] : 32'd0;
	assign rsp.lost_count = lost_s1;

endmodule

// ===== design/mcfb_checker.sv =====
// ----------------------------------------------------------------------------
// mcfb_checker
// Port-level checks on the FIFO bank, attached to the top level by bind.
// ----------------------------------------------------------------------------
module mcfb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input mcfb_pkg::req_t req,
	input logic           done,
	input mcfb_pkg::rsp_t rsp
);

	import mcfb_pkg::*;

	// Every accepted transaction gets its response in the next cycle.
	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("response missing after accepted transaction");

	// A response never appears without a transaction in the cycle before.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("response without a transaction");

	// A bad index reports neither data nor a lost count.
	a_badidx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_BADIDX |-> rsp.read_data == 32'd0 && rsp.lost_count == 32'd0)
		else $error("bad index response carries data");

	// Read data is zero unless a read to a valid FIFO succeeded.
	a_data_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		done && ($past(req.req_type) != REQ_READ || rsp.status != ST_OK)
			|-> rsp.read_data == 32'd0)
		else $error("read data on a non-read response");

endmodule

bind multi_channel_fifo_bank mcfb_checker u_mcfb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);
